[src/tti_pkg.sv]
package tti_pkg;

  localparam int unsigned REQ_TYPE_W  = 3;
  localparam int unsigned BUS_W       = 11;
  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned TX_CHAR_W   = 7;
  localparam int unsigned CHAN_W      = 3;
  localparam int unsigned CNT_W       = 20;
  localparam int unsigned BIT_TICKS_W = 16;

  localparam logic [BIT_TICKS_W-1:0] BIT_TICKS_RESET = 16'd100;

  // bus_data flag positions for control set
  localparam int unsigned BUS_SET_ODONE = 3;
  localparam int unsigned BUS_SET_OBUSY = 4;
  localparam int unsigned BUS_SET_IDONE = 5;
  localparam int unsigned BUS_SET_IBUSY = 6;
  localparam int unsigned BUS_CLR_ODONE = 7;
  localparam int unsigned BUS_CLR_OBUSY = 8;
  localparam int unsigned BUS_CLR_IDONE = 9;
  localparam int unsigned BUS_CLR_IBUSY = 10;

  typedef enum logic [REQ_TYPE_W-1:0] {
    REQ_RESET     = 3'd0,
    REQ_CONO_CLR  = 3'd1,
    REQ_CONO_SET  = 3'd2,
    REQ_DATAO_CLR = 3'd3,
    REQ_DATAO_SET = 3'd4,
    REQ_DATAI     = 3'd5,
    REQ_STATUS    = 3'd6,
    REQ_TICK      = 3'd7
  } req_e;

  typedef struct packed {
    logic [REQ_TYPE_W-1:0] req_type;
    logic [BUS_W-1:0]      bus_data;
    logic                  power;
    logic                  rx_valid;
    logic [CHAR_W-1:0]     rx_char;
  } req_t;

  typedef struct packed {
    logic [CHAR_W-1:0]    read_data;
    logic [CHAN_W-1:0]    irq_level;
    logic                 tx_valid;
    logic [TX_CHAR_W-1:0] tx_char;
  } rsp_t;

endpackage

[src/tti_req_if.sv]
interface tti_req_if import tti_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [REQ_TYPE_W-1:0] req_type;
  logic [BUS_W-1:0]      bus_data;
  logic                  power;
  logic                  rx_valid;
  logic [CHAR_W-1:0]     rx_char;

  modport source (output valid, req_type, bus_data, power, rx_valid, rx_char,
                  input ready);
  modport sink   (input valid, req_type, bus_data, power, rx_valid, rx_char,
                  output ready);
endinterface

[src/tti_rsp_if.sv]
interface tti_rsp_if import tti_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CHAR_W-1:0]    read_data;
  logic [CHAN_W-1:0]    irq_level;
  logic                 tx_valid;
  logic [TX_CHAR_W-1:0] tx_char;

  modport source (output valid, read_data, irq_level, tx_valid, tx_char,
                  input ready);
  modport sink   (input valid, read_data, irq_level, tx_valid, tx_char,
                  output ready);
endinterface

[src/tti_in_stage.sv]
module tti_in_stage import tti_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  tti_req_if.sink   req_i,
  input  logic      advance_i,
  output logic      valid_o,
  output req_t      data_o
);

  logic valid_q, valid_d;
  req_t data_q;
  logic fire;

  assign req_i.ready = !valid_q || advance_i;
  assign fire        = req_i.valid && req_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (fire) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      data_q.req_type <= req_i.req_type;
      data_q.bus_data <= req_i.bus_data;
      data_q.power    <= req_i.power;
      data_q.rx_valid <= req_i.rx_valid;
      data_q.rx_char  <= req_i.rx_char;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

[src/tti_engine.sv]
module tti_engine import tti_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [BIT_TICKS_W-1:0] cfg_wdata_i,
  input  logic                   step_i,
  input  req_t                   req_i,
  output rsp_t                   rsp_o
);

  logic [BIT_TICKS_W-1:0] bit_ticks_q;

  logic [CHAN_W-1:0] channel_q, channel_d;
  logic              out_busy_q, out_busy_d;
  logic              out_done_q, out_done_d;
  logic              in_busy_q, in_busy_d;
  logic              in_done_q, in_done_d;
  logic              out_active_q, out_active_d;
  logic [CHAR_W-1:0] out_char_q, out_char_d;
  logic [CHAR_W-1:0] in_char_q, in_char_d;
  logic              in_phase_q, in_phase_d;
  logic [CNT_W-1:0]  out_count_q, out_count_d;
  logic [CNT_W-1:0]  in_count_q, in_count_d;

  logic [CNT_W-1:0] bt1, bt2, bt9, bt11;
  logic [CNT_W-1:0] out_count_dec, in_count_dec;
  logic [BUS_W-1:0] bus;
  rsp_t             rsp;

  // bit time multiples as shift-add, all fit in the count width
  assign bt1  = CNT_W'(bit_ticks_q);
  assign bt2  = bt1 << 1;
  assign bt9  = (bt1 << 3) + bt1;
  assign bt11 = (bt1 << 3) + (bt1 << 1) + bt1;

  assign out_count_dec = (out_count_q == '0) ? '0 : out_count_q - CNT_W'(1);
  assign in_count_dec  = (in_count_q == '0) ? '0 : in_count_q - CNT_W'(1);
  assign bus           = req_i.bus_data;

  always_comb begin
    channel_d    = channel_q;
    out_busy_d   = out_busy_q;
    out_done_d   = out_done_q;
    in_busy_d    = in_busy_q;
    in_done_d    = in_done_q;
    out_active_d = out_active_q;
    out_char_d   = out_char_q;
    in_char_d    = in_char_q;
    in_phase_d   = in_phase_q;
    out_count_d  = out_count_q;
    in_count_d   = in_count_q;
    rsp          = '0;

    case (req_e'(req_i.req_type))
      REQ_RESET: begin
        channel_d  = '0;
        out_busy_d = 1'b0;
        out_done_d = 1'b0;
        in_busy_d  = 1'b0;
        in_done_d  = 1'b0;
        in_count_d = '0;
      end
      REQ_CONO_CLR: begin
        channel_d = '0;
      end
      REQ_CONO_SET: begin
        channel_d  = channel_q | bus[CHAN_W-1:0];
        // clears win over sets
        out_done_d = (out_done_q | bus[BUS_SET_ODONE]) & ~bus[BUS_CLR_ODONE];
        out_busy_d = (out_busy_q | bus[BUS_SET_OBUSY]) & ~bus[BUS_CLR_OBUSY];
        in_done_d  = (in_done_q | bus[BUS_SET_IDONE]) & ~bus[BUS_CLR_IDONE];
        in_busy_d  = (in_busy_q | bus[BUS_SET_IBUSY]) & ~bus[BUS_CLR_IBUSY];
      end
      REQ_DATAO_CLR: begin
        out_busy_d = 1'b1;
        out_done_d = 1'b0;
      end
      REQ_DATAO_SET: begin
        out_char_d   = out_char_q | bus[CHAR_W-1:0];
        out_active_d = 1'b1;
        out_count_d  = bt11;
      end
      REQ_DATAI: begin
        in_done_d     = 1'b0;
        rsp.read_data = in_char_q;
      end
      REQ_STATUS: begin
        rsp.read_data = {1'b0, in_busy_q, in_done_q, out_busy_q, out_done_q, channel_q};
      end
      REQ_TICK: begin
        if (!req_i.power) begin
          out_active_d = 1'b0;
          in_phase_d   = 1'b0;
          out_count_d  = out_count_dec;
          in_count_d   = in_count_dec;
        end else begin
          if (out_active_q && out_count_q == '0) begin
            out_active_d = 1'b0;
            rsp.tx_valid = 1'b1;
            rsp.tx_char  = out_char_q[TX_CHAR_W-1:0];
            out_char_d   = '0;
            out_busy_d   = 1'b0;
            out_done_d   = 1'b1;
          end else begin
            out_count_d = out_count_dec;
          end
          if (in_count_q == '0) begin
            in_count_d = bt1;
            if (!in_phase_q) begin
              // start bit sampled only here
              if (req_i.rx_valid) begin
                in_char_d  = req_i.rx_char;
                in_busy_d  = 1'b1;
                in_done_d  = 1'b0;
                in_count_d = bt9;
                in_phase_d = 1'b1;
              end
            end else if (in_busy_q) begin
              in_busy_d  = 1'b0;
              in_done_d  = 1'b1;
              in_count_d = bt2;
              in_phase_d = 1'b0;
            end
          end else begin
            in_count_d = in_count_q - CNT_W'(1);
          end
        end
      end
      default: begin
      end
    endcase

    if (channel_d != '0 && (in_done_d || out_done_d)) begin
      rsp.irq_level = channel_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_ticks_q  <= BIT_TICKS_RESET;
      channel_q    <= '0;
      out_busy_q   <= 1'b0;
      out_done_q   <= 1'b0;
      in_busy_q    <= 1'b0;
      in_done_q    <= 1'b0;
      out_active_q <= 1'b0;
      out_char_q   <= '0;
      in_char_q    <= '0;
      in_phase_q   <= 1'b0;
      out_count_q  <= '0;
      in_count_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        bit_ticks_q <= cfg_wdata_i;
      end
      if (step_i) begin
        channel_q    <= channel_d;
        out_busy_q   <= out_busy_d;
        out_done_q   <= out_done_d;
        in_busy_q    <= in_busy_d;
        in_done_q    <= in_done_d;
        out_active_q <= out_active_d;
        out_char_q   <= out_char_d;
        in_char_q    <= in_char_d;
        in_phase_q   <= in_phase_d;
        out_count_q  <= out_count_d;
        in_count_q   <= in_count_d;
      end
    end
  end

  assign rsp_o = rsp;

endmodule

[src/tti_out_reg.sv]
module tti_out_reg import tti_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  rsp_t       rsp_i,
  output logic       accept_o,
  tti_rsp_if.source  rsp_o
);

  logic valid_q, valid_d;
  rsp_t data_q;

  assign accept_o = !valid_q || rsp_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= rsp_i;
    end
  end

  assign rsp_o.valid     = valid_q;
  assign rsp_o.read_data = data_q.read_data;
  assign rsp_o.irq_level = data_q.irq_level;
  assign rsp_o.tx_valid  = data_q.tx_valid;
  assign rsp_o.tx_char   = data_q.tx_char;

endmodule

[src/teletype_io_interface_core.sv]
// Channel   Dir  Beat contents
// req_i     in   req_type, bus_data, power, rx_valid, rx_char
// rsp_o     out  read_data, irq_level, tx_valid, tx_char
// cfg       in   cfg_we_i / cfg_wdata_i -> bit_ticks (no read-back)
//
// One request beat per clock while rsp_o is not stalled; its result beat reaches
// rsp_o via the input register, then the state update feeding the result register.
// Reset: bit_ticks = 100, all device state and both stage valids cleared.
// A stalled rsp_o holds its beat; the input register still takes one more
// beat, after which req_i.ready drops until rsp_o drains.
module teletype_io_interface_core import tti_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [BIT_TICKS_W-1:0] cfg_wdata_i,
  tti_req_if.sink                req_i,
  tti_rsp_if.source              rsp_o
);

  logic s1_valid;
  req_t s1_data;
  rsp_t step_rsp;
  logic out_accept;
  logic advance;

  assign advance = s1_valid && out_accept;

  tti_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req_i),
    .advance_i (advance),
    .valid_o   (s1_valid),
    .data_o    (s1_data)
  );

  tti_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .step_i      (advance),
    .req_i       (s1_data),
    .rsp_o       (step_rsp)
  );

  tti_out_reg u_out_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (advance),
    .rsp_i    (step_rsp),
    .accept_o (out_accept),
    .rsp_o    (rsp_o)
  );

endmodule

[src/tti_checker.sv]
module tti_checker import tti_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_i,
  input logic                 out_valid_i,
  input logic                 out_ready_i,
  input logic [CHAR_W-1:0]    read_data_i,
  input logic [CHAN_W-1:0]    irq_level_i,
  input logic                 tx_valid_i,
  input logic [TX_CHAR_W-1:0] tx_char_i
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(read_data_i) &&
      $stable(irq_level_i) && $stable(tx_valid_i) && $stable(tx_char_i))
    else $error("result beat changed while stalled");

  // input side only backs up when the result side is stalled
  a_ready_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input not ready without output stall");

  // a fresh result beat comes from an accepted request, via the input register
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i, 2))
    else $error("result beat without matching request");

endmodule

bind teletype_io_interface_core tti_checker u_tti_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (req_i.valid),
  .in_ready_i  (req_i.ready),
  .out_valid_i (rsp_o.valid),
  .out_ready_i (rsp_o.ready),
  .read_data_i (rsp_o.read_data),
  .irq_level_i (rsp_o.irq_level),
  .tx_valid_i  (rsp_o.tx_valid),
  .tx_char_i   (rsp_o.tx_char)
);

[dv/tb_teletype_io_interface_core.sv]
module tb_teletype_io_interface_core;
  import tti_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;

  // Shadow of the device state; predicts one response beat per request beat.
  class teletype_shadow;
    logic [BIT_TICKS_W-1:0] bit_ticks;
    logic [CHAN_W-1:0]      chan;
    logic                   o_busy, o_done, i_busy, i_done, o_active, i_phase;
    logic [CHAR_W-1:0]      o_char, i_char;
    logic [CNT_W-1:0]       o_cnt, i_cnt;
    logic [CHAN_W-1:0]      irq;
    rsp_t                   pending_rsp[$];
    int unsigned            mismatches;

    function new();
      bit_ticks  = BIT_TICKS_RESET;
      chan       = '0;
      o_busy     = 1'b0;
      o_done     = 1'b0;
      i_busy     = 1'b0;
      i_done     = 1'b0;
      o_active   = 1'b0;
      i_phase    = 1'b0;
      o_char     = '0;
      i_char     = '0;
      o_cnt      = '0;
      i_cnt      = '0;
      irq        = '0;
      mismatches = 0;
    endfunction

    function void note_request(req_t r);
      rsp_t             exp;
      logic [CNT_W-1:0] one_bit;
      exp     = '0;
      one_bit = CNT_W'(bit_ticks);
      case (req_e'(r.req_type))
        REQ_RESET: begin
          chan   = '0;
          o_busy = 1'b0;
          o_done = 1'b0;
          i_busy = 1'b0;
          i_done = 1'b0;
          i_cnt  = '0;
        end
        REQ_CONO_CLR: chan = '0;
        REQ_CONO_SET: begin
          chan = chan | r.bus_data[CHAN_W-1:0];
          if (r.bus_data[BUS_SET_ODONE]) o_done = 1'b1;
          if (r.bus_data[BUS_SET_OBUSY]) o_busy = 1'b1;
          if (r.bus_data[BUS_SET_IDONE]) i_done = 1'b1;
          if (r.bus_data[BUS_SET_IBUSY]) i_busy = 1'b1;
          if (r.bus_data[BUS_CLR_ODONE]) o_done = 1'b0;
          if (r.bus_data[BUS_CLR_OBUSY]) o_busy = 1'b0;
          if (r.bus_data[BUS_CLR_IDONE]) i_done = 1'b0;
          if (r.bus_data[BUS_CLR_IBUSY]) i_busy = 1'b0;
        end
        REQ_DATAO_CLR: begin
          o_busy = 1'b1;
          o_done = 1'b0;
        end
        REQ_DATAO_SET: begin
          o_char   = o_char | r.bus_data[CHAR_W-1:0];
          o_active = 1'b1;
          o_cnt    = CNT_W'(11 * one_bit);
        end
        REQ_DATAI: begin
          i_done        = 1'b0;
          exp.read_data = i_char;
        end
        REQ_STATUS: exp.read_data = {1'b0, i_busy, i_done, o_busy, o_done, chan};
        default: begin
          if (!r.power) begin
            o_active = 1'b0;
            i_phase  = 1'b0;
            if (o_cnt != 0) o_cnt = o_cnt - 1'b1;
            if (i_cnt != 0) i_cnt = i_cnt - 1'b1;
          end else begin
            if (o_active && o_cnt == 0) begin
              o_active     = 1'b0;
              exp.tx_valid = 1'b1;
              exp.tx_char  = o_char[TX_CHAR_W-1:0];
              o_char       = '0;
              o_busy       = 1'b0;
              o_done       = 1'b1;
            end else if (o_cnt != 0) begin
              o_cnt = o_cnt - 1'b1;
            end
            if (i_cnt == 0) begin
              i_cnt = one_bit;
              if (!i_phase) begin
                // a character is only sampled when the timer fires in phase 0
                if (r.rx_valid) begin
                  i_char  = r.rx_char;
                  i_busy  = 1'b1;
                  i_done  = 1'b0;
                  i_cnt   = CNT_W'(9 * one_bit);
                  i_phase = 1'b1;
                end
              end else if (i_busy) begin
                i_busy  = 1'b0;
                i_done  = 1'b1;
                i_cnt   = CNT_W'(2 * one_bit);
                i_phase = 1'b0;
              end
            end else begin
              i_cnt = i_cnt - 1'b1;
            end
          end
        end
      endcase
      irq           = (chan != 0 && (i_done || o_done)) ? chan : '0;
      exp.irq_level = irq;
      pending_rsp.push_back(exp);
    endfunction

    function void report(string what, logic [31:0] e, logic [31:0] a);
      mismatches++;
      if (mismatches <= 10) $display("mismatch %s: expected %0h got %0h", what, e, a);
    endfunction

    function void check_beat(rsp_t got);
      rsp_t exp;
      if (pending_rsp.size() == 0) begin
        report("beat with nothing pending", '0, 32'(got));
        return;
      end
      exp = pending_rsp.pop_front();
      if (got.read_data !== exp.read_data)
        report("read_data", 32'(exp.read_data), 32'(got.read_data));
      if (got.irq_level !== exp.irq_level)
        report("irq_level", 32'(exp.irq_level), 32'(got.irq_level));
      if (got.tx_valid !== exp.tx_valid)
        report("tx_valid", 32'(exp.tx_valid), 32'(got.tx_valid));
      if (got.tx_char !== exp.tx_char)
        report("tx_char", 32'(exp.tx_char), 32'(got.tx_char));
    endfunction
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [BIT_TICKS_W-1:0] cfg_wdata_i;

  tti_req_if req_if ();
  tti_rsp_if rsp_if ();

  teletype_io_interface_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req_i      (req_if),
    .rsp_o      (rsp_if)
  );

  teletype_shadow shadow = new();
  bit             no_gaps = 1'b0;
  int unsigned    sent = 0;
  int unsigned    beats_seen = 0;
  int unsigned    cycles = 0;

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_teletype_io_interface_core: errors");
      $finish;
    end
  end

  function automatic req_t make_req(req_e kind, logic [BUS_W-1:0] bus, logic pwr, logic rxv,
                                    logic [CHAR_W-1:0] ch);
    req_t r;
    r.req_type = kind;
    r.bus_data = bus;
    r.power    = pwr;
    r.rx_valid = rxv;
    r.rx_char  = ch;
    return r;
  endfunction

  task automatic send_item(input req_t r);
    while (!no_gaps && $urandom_range(0, 99) < 33) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid    <= 1'b1;
    req_if.req_type <= r.req_type;
    req_if.bus_data <= r.bus_data;
    req_if.power    <= r.power;
    req_if.rx_valid <= r.rx_valid;
    req_if.rx_char  <= r.rx_char;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    shadow.note_request(r);
    sent++;
  endtask

  task automatic send_cmd(input req_e kind, input logic [BUS_W-1:0] bus);
    send_item(make_req(kind, bus, 1'($urandom), 1'($urandom), CHAR_W'($urandom)));
  endtask

  task automatic send_tick(input logic pwr, input logic rxv, input logic [CHAR_W-1:0] ch);
    send_item(make_req(REQ_TICK, BUS_W'($urandom), pwr, rxv, ch));
  endtask

  task automatic drain();
    req_if.valid <= 1'b0;
    while (shadow.pending_rsp.size() != 0) @(posedge clk_i);
  endtask

  // only called with both channels empty
  task automatic write_bit_ticks(input logic [BIT_TICKS_W-1:0] bt);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= bt;
    @(posedge clk_i);
    cfg_we_i         <= 1'b0;
    shadow.bit_ticks = bt;
  endtask

  task automatic send_ticks(input int unsigned n, input int unsigned rx_pct);
    repeat (n) begin
      send_tick($urandom_range(0, 49) != 0, $urandom_range(0, 99) < rx_pct, CHAR_W'($urandom));
    end
  endtask

  function automatic int unsigned ticks_for(int unsigned bit_times);
    int unsigned n;
    n = bit_times * shadow.bit_ticks + 1 + $urandom_range(0, 2);
    return (n > 120) ? 120 : n;
  endfunction

  task automatic send_noise();
    int unsigned pick;
    req_e        kind;
    pick = $urandom_range(0, 99);
    if (pick < 3) kind = REQ_RESET;
    else if (pick < 50) kind = REQ_TICK;
    else kind = req_e'($urandom_range(1, 6));
    send_item(make_req(kind, BUS_W'($urandom), $urandom_range(0, 9) != 0, 1'($urandom),
                       CHAR_W'($urandom)));
  endtask

  task automatic run_transmit();
    if ($urandom_range(0, 1)) send_cmd(REQ_DATAO_CLR, BUS_W'($urandom));
    // sets only, so the channel and done flags usually survive
    if ($urandom_range(0, 2) == 0) send_cmd(REQ_CONO_SET, {4'b0000, 4'($urandom), 3'($urandom)});
    send_cmd(REQ_DATAO_SET, BUS_W'($urandom));
    send_ticks(ticks_for(11), 30);
    send_cmd(REQ_STATUS, BUS_W'($urandom));
    if ($urandom_range(0, 1)) send_cmd(REQ_DATAI, BUS_W'($urandom));
  endtask

  task automatic run_receive();
    send_ticks(ticks_for(10) + 2, 60);
    send_cmd(REQ_DATAI, BUS_W'($urandom));
    send_cmd(REQ_STATUS, BUS_W'($urandom));
  endtask

  task automatic run_phase(input logic [BIT_TICKS_W-1:0] bt, input int unsigned items);
    int unsigned goal;
    int unsigned pick;
    goal = sent + items;
    write_bit_ticks(bt);
    while (sent < goal) begin
      pick = $urandom_range(0, 9);
      if (pick < 3) run_transmit();
      else if (pick < 7) run_receive();
      else repeat ($urandom_range(1, 5)) send_noise();
    end
    drain();
  endtask

  task automatic run_directed();
    send_cmd(REQ_STATUS, '0);
    send_cmd(REQ_CONO_SET, 11'h7FF);    // clears beat sets
    send_cmd(REQ_STATUS, '0);
    send_cmd(REQ_CONO_SET, 11'h07F);    // channel 7, all flags set
    send_cmd(REQ_STATUS, '0);
    send_cmd(REQ_DATAI, '0);
    send_cmd(REQ_CONO_CLR, '0);         // request drops right away
    send_cmd(REQ_RESET, 11'h7FF);
    drain();
    write_bit_ticks('0);                // every timer fires on the next tick
    send_cmd(REQ_CONO_SET, 11'h005);
    send_cmd(REQ_DATAO_CLR, '0);
    send_cmd(REQ_DATAO_SET, 11'h7FF);
    send_tick(1'b1, 1'b0, 8'h00);       // transmit completes
    send_tick(1'b1, 1'b1, 8'hFF);       // receive starts
    send_tick(1'b1, 1'b1, 8'h00);       // receive done, offered char ignored
    send_cmd(REQ_DATAI, '0);
    send_tick(1'b1, 1'b1, 8'h00);
    send_cmd(REQ_CONO_SET, 11'h400);    // drop in_busy during phase 1
    send_tick(1'b1, 1'b0, 8'h00);       // reload, phase stays 1
    send_tick(1'b1, 1'b1, 8'hAA);
    send_cmd(REQ_DATAO_SET, 11'h000);
    send_tick(1'b0, 1'b1, 8'h5A);       // power off kills transmit and receive phase
    send_tick(1'b1, 1'b0, 8'h00);
    send_tick(1'b1, 1'b1, 8'h55);
    send_cmd(REQ_STATUS, '0);
    send_cmd(REQ_RESET, '0);
    send_cmd(REQ_DATAI, '0);
    drain();
  endtask

  initial begin : rsp_side
    int unsigned hold;
    rsp_t        got;
    hold = 0;
    rsp_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (rsp_if.valid && rsp_if.ready) begin
        got.read_data = rsp_if.read_data;
        got.irq_level = rsp_if.irq_level;
        got.tx_valid  = rsp_if.tx_valid;
        got.tx_char   = rsp_if.tx_char;
        shadow.check_beat(got);
        beats_seen++;
        if (beats_seen == 600) hold = 150;  // long back-pressure while input keeps coming
      end
      if (hold > 0) begin
        hold--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= no_gaps || ($urandom_range(0, 99) >= 33);
      end
    end
  end

  initial begin : req_side
    rst_ni          <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_wdata_i     <= '0;
    req_if.valid    <= 1'b0;
    req_if.req_type <= REQ_RESET;
    req_if.bus_data <= '0;
    req_if.power    <= 1'b0;
    req_if.rx_valid <= 1'b0;
    req_if.rx_char  <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    run_phase(16'd1, 250);
    run_phase(16'd2, 250);
    run_phase(16'd3, 250);
    run_phase(16'hFFFF, 120);
    no_gaps = 1'b1;
    run_phase(16'd4, 250);
    no_gaps = 1'b0;
    run_phase(16'd0, 250);
    run_phase(16'd9, 250);
    run_phase(16'd1, 250);
    drain();
    repeat (20) @(posedge clk_i);
    if (shadow.mismatches == 0 && shadow.pending_rsp.size() == 0) begin
      $display("tb_teletype_io_interface_core: clean");
    end else begin
      $display("tb_teletype_io_interface_core: errors");
    end
    $finish;
  end

endmodule

[files.f]
src/tti_pkg.sv
src/tti_req_if.sv
src/tti_rsp_if.sv
src/tti_in_stage.sv
src/tti_engine.sv
src/tti_out_reg.sv
src/teletype_io_interface_core.sv
src/tti_checker.sv
dv/tb_teletype_io_interface_core.sv
